// File: rtl/core/upes_pkg.sv
package upes_pkg;

    localparam int TIMER_BITS = 17;
    localparam int LEND_W     = 17;
    localparam int CMP_W      = (TIMER_BITS > LEND_W) ? TIMER_BITS : LEND_W;
    localparam int TIME_W     = 17;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_TICKS = 2'd2;

    localparam logic [7:0]  PULSE_COUNT_RST  = 8'd10;
    localparam logic [9:0]  RELAX_TICKS_RST  = 10'd20;
    localparam logic [15:0] LISTEN_TICKS_RST = 16'd600;

    typedef enum logic [2:0] {
        PH_OFF    = 3'd0,
        PH_EMIT   = 3'd1,
        PH_DIS    = 3'd2,
        PH_LISTEN = 3'd3,
        PH_FOUND  = 3'd4
    } t_phase;

    typedef struct packed {
        logic              drive_pos;
        logic              drive_neg;
        logic              drive_enable;
        t_phase            phase;
        logic              echo_valid;
        logic [TIME_W-1:0] echo_start;
        logic [TIME_W-1:0] echo_end;
    } t_result;

endpackage

// File: rtl/core/ultrasonic_ping_echo_sequencer.sv
// Ultrasonic ping/echo sequencer. Each request is one carrier half-period tick
// carrying the sampled echo pin, and each tick yields exactly one result: the
// piezo pin levels, the phase (off, emit, discharge, listen, echo found) and
// the echo start/end tick stamps. A tick is accepted every clock cycle in
// which o_stall is low, and its result is registered. A two-entry
// output stage (output register plus skid register) lets a tick be taken
// while an earlier result still waits, so input stall only rises when both
// entries are full. Configuration (pulse_count, relax_ticks, listen_ticks)
// must be written while no result is outstanding.
module ultrasonic_ping_echo_sequencer
    import upes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_echo_level,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_drive_pos,
    output logic                  o_drive_neg,
    output logic                  o_drive_enable,
    output logic [2:0]            o_phase,
    output logic                  o_echo_valid,
    output logic [TIME_W-1:0]     o_echo_start,
    output logic [TIME_W-1:0]     o_echo_end
);

    logic [7:0]  r_pulse_count;
    logic [9:0]  r_relax_ticks;
    logic [15:0] r_listen_ticks;

    logic [TIMER_BITS-1:0] r_tick, n_tick;
    t_phase                r_phase, n_phase;
    logic                  r_pos, n_pos;
    logic                  r_neg, n_neg;
    logic                  r_last_echo, n_last_echo;
    logic [7:0]            r_edges, n_edges;
    logic [TIME_W-1:0]     r_start, n_start;
    logic [TIME_W-1:0]     r_end, n_end;
    logic                  r_found, n_found;

    t_result r_out, r_skid, n_result;
    logic    r_out_vld, r_skid_vld;

    logic [8:0]        e_end;
    logic [10:0]       relax_end;
    logic [LEND_W-1:0] l_end;
    logic [CMP_W-1:0]  tick_cmp;
    t_phase            want;
    logic              want_set;
    logic              accept, take;

    assign o_stall = r_skid_vld;
    assign accept  = i_valid && !r_skid_vld;
    assign take    = r_out_vld && !i_stall;

    // Phase boundaries from the current configuration.
    assign e_end     = {r_pulse_count, 1'b0};
    assign relax_end = 11'(e_end) + 11'(r_relax_ticks);
    assign l_end     = LEND_W'(relax_end) + LEND_W'(r_listen_ticks);
    assign tick_cmp  = CMP_W'(r_tick);

    always_comb begin
        want     = r_phase;
        want_set = 1'b1;
        if (tick_cmp > CMP_W'(l_end)) begin
            want = PH_OFF;
        end else if (tick_cmp > CMP_W'(relax_end)) begin
            want = PH_LISTEN;
        end else if (tick_cmp > CMP_W'(e_end)) begin
            want = PH_DIS;
        end else if (tick_cmp != '0) begin
            want = PH_EMIT;
        end else begin
            want_set = 1'b0;
        end
    end

    // Next state: phase entry first, then the action of the resulting phase.
    always_comb begin
        n_tick      = r_tick;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_last_echo = r_last_echo;
        n_edges     = r_edges;
        n_start     = r_start;
        n_end       = r_end;
        n_found     = r_found;

        // A found echo holds through the rest of the listen window.
        if (want_set && want != r_phase &&
            !(r_phase == PH_FOUND && want == PH_LISTEN)) begin
            n_phase = want;
            case (want)
                PH_OFF: begin
                    n_tick = '0;
                end
                PH_EMIT: begin
                    n_pos = 1'b1;
                    n_neg = 1'b0;
                end
                PH_DIS: begin
                    n_pos = 1'b0;
                    n_neg = 1'b0;
                end
                default: begin
                    n_last_echo = i_echo_level;
                    n_edges     = '0;
                    n_start     = '0;
                    n_end       = '0;
                    n_found     = 1'b0;
                end
            endcase
        end

        case (n_phase)
            PH_EMIT: begin
                n_pos = ~n_pos;
                n_neg = ~n_neg;
            end
            PH_LISTEN: begin
                if (i_echo_level != n_last_echo) begin
                    n_last_echo = i_echo_level;
                    if (n_edges != 8'hFF) begin
                        n_edges = n_edges + 8'd1;
                    end
                end else if (n_edges < r_pulse_count) begin
                    n_edges = '0;
                    n_start = TIME_W'(n_tick);
                end else begin
                    n_phase = PH_FOUND;
                    n_end   = TIME_W'(n_tick);
                    n_found = 1'b1;
                end
            end
            default: ;
        endcase

        n_tick = n_tick + TIMER_BITS'(1);
    end

    // Result fields from the post-tick state.
    always_comb begin
        n_result.drive_enable = (n_phase == PH_EMIT) || (n_phase == PH_DIS);
        n_result.drive_pos    = n_result.drive_enable && n_pos;
        n_result.drive_neg    = n_result.drive_enable && n_neg;
        n_result.phase        = n_phase;
        n_result.echo_valid   = n_found;
        n_result.echo_start   = n_start;
        n_result.echo_end     = n_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count  <= PULSE_COUNT_RST;
            r_relax_ticks  <= RELAX_TICKS_RST;
            r_listen_ticks <= LISTEN_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PULSE_COUNT:  r_pulse_count  <= i_cfg_data[7:0];
                CFG_RELAX_TICKS:  r_relax_ticks  <= i_cfg_data[9:0];
                CFG_LISTEN_TICKS: r_listen_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_phase     <= PH_EMIT;
            r_pos       <= 1'b1;
            r_neg       <= 1'b0;
            r_last_echo <= 1'b0;
            r_edges     <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_found     <= 1'b0;
        end else if (accept) begin
            r_tick      <= n_tick;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_neg       <= n_neg;
            r_last_echo <= n_last_echo;
            r_edges     <= n_edges;
            r_start     <= n_start;
            r_end       <= n_end;
            r_found     <= n_found;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= accept;
            end
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || take) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_drive_pos    = r_out.drive_pos;
    assign o_drive_neg    = r_out.drive_neg;
    assign o_drive_enable = r_out.drive_enable;
    assign o_phase        = r_out.phase;
    assign o_echo_valid   = r_out.echo_valid;
    assign o_echo_start   = r_out.echo_start;
    assign o_echo_end     = r_out.echo_end;

endmodule

// File: rtl/core/upes_checker.sv
module upes_checker
    import upes_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_drive_pos,
    input logic              o_drive_neg,
    input logic              o_drive_enable,
    input logic [2:0]        o_phase,
    input logic              o_echo_valid,
    input logic [TIME_W-1:0] o_echo_start,
    input logic [TIME_W-1:0] o_echo_end
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_phase) && $stable(o_echo_end)
                               && $stable(o_echo_start))
        else $error("stalled result changed");

    a_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive_enable == (o_phase == PH_EMIT || o_phase == PH_DIS))
        else $error("drive enable does not match phase");

    a_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_drive_enable |-> !o_drive_pos && !o_drive_neg)
        else $error("released pins reported high");

    a_antiphase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase == PH_EMIT |-> o_drive_pos != o_drive_neg)
        else $error("burst pins not in antiphase");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase == PH_FOUND |-> o_echo_valid)
        else $error("echo found phase without echo flag");

endmodule

bind ultrasonic_ping_echo_sequencer upes_checker u_upes_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_drive_pos    (o_drive_pos),
    .o_drive_neg    (o_drive_neg),
    .o_drive_enable (o_drive_enable),
    .o_phase        (o_phase),
    .o_echo_valid   (o_echo_valid),
    .o_echo_start   (o_echo_start),
    .o_echo_end     (o_echo_end)
);
